>>> rtl/dlle_pkg.sv
// ----------------------------------------------------------------------------
// dlle_pkg
// Shared types, constants and helpers for the doubly linked list engine.
// ----------------------------------------------------------------------------
package dlle_pkg;

	// Node table size and derived widths
	localparam int NODES  = 64;
	localparam int ID_W   = $clog2(NODES);
	localparam int LINK_W = $clog2(NODES + 1);
	localparam int CNT_W  = $clog2(NODES + 1);
	localparam int CFG_W  = 7;

	// Link value that marks "no node"
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

	// Reset value of the capacity register
	localparam logic [CFG_W-1:0] MAX_ITEMS_RST = CFG_W'(64);

	// Operation and location codes
	localparam logic       ACT_PUT  = 1'b0;
	localparam logic       ACT_GET  = 1'b1;
	localparam logic [1:0] LOC_HEAD = 2'd0;
	localparam logic [1:0] LOC_TAIL = 2'd1;

	// Register index, taken from paddr[2]
	localparam logic REG_MAX_ITEMS = 1'b0;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_WR1,
		S_WR2,
		S_DONE
	} seq_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUT_FIRST,
		OP_PUT_HEAD,
		OP_PUT_TAIL,
		OP_PUT_AFTER,
		OP_GET
	} op_t;

	// One link RAM port: one write and one read address per cycle
	typedef struct packed {
		logic              we;
		logic [ID_W-1:0]   waddr;
		logic [LINK_W-1:0] wdata;
		logic [ID_W-1:0]   raddr;
	} ram_req_t;

	// Result transaction
	typedef struct packed {
		logic [ID_W-1:0]  removed_node;
		status_t          status;
		logic [CNT_W-1:0] item_count;
		logic             is_empty;
		logic             is_full;
	} result_t;

	// A link points to a real node when it is below the null code
	function automatic logic is_real(input logic [LINK_W-1:0] link);
		return link < NULL_LINK;
	endfunction

endpackage

>>> rtl/dlle_link_ram.sv
// ----------------------------------------------------------------------------
// dlle_link_ram
// Link table RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dlle_link_ram (
	input  logic                        clk,
	input  dlle_pkg::ram_req_t          req,
	output logic [dlle_pkg::LINK_W-1:0] rdata_q
);
	import dlle_pkg::*;

	logic [LINK_W-1:0] mem [NODES];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

endmodule

>>> rtl/dlle_seq.sv
// ----------------------------------------------------------------------------
// dlle_seq
// Operation sequencer: checks an operation, reads the target's links for a put
// after a reference or a get, issues the link writes, up to two per RAM, then reports the result.
// ----------------------------------------------------------------------------
module dlle_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        action,
	input  logic [1:0]                  location,
	input  logic [dlle_pkg::ID_W-1:0]   node_id,
	input  logic                        ref_valid,
	input  logic [dlle_pkg::ID_W-1:0]   ref_node,
	input  logic [dlle_pkg::CFG_W-1:0]  max_items,
	input  logic [dlle_pkg::LINK_W-1:0] next_rdata_q,
	input  logic [dlle_pkg::LINK_W-1:0] prev_rdata_q,
	output dlle_pkg::ram_req_t          next_req,
	output dlle_pkg::ram_req_t          prev_req,
	output logic                        busy,
	output logic                        done,
	output dlle_pkg::result_t           result
);
	import dlle_pkg::*;

	seq_state_t state_q, state_d;
	op_t        op_q, op_c;
	status_t    status_q, status_c;

	// Latched transaction
	logic              act_q;
	logic [1:0]        loc_q;
	logic [ID_W-1:0]   id_q;
	logic              refv_q;
	logic [ID_W-1:0]   ref_q;

	// Work registers
	logic [ID_W-1:0]   tgt_q;
	logic [LINK_W-1:0] p_q;
	logic [LINK_W-1:0] n_q;

	// List state
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [NODES-1:0]  member_q;

	logic [CNT_W-1:0]  cap_c;
	logic              full_c;
	logic              rel_c;
	logic              head_sel_c;
	logic              list_empty_c;
	logic [LINK_W-1:0] tgt_link_c;
	logic [LINK_W-1:0] id_link;
	logic [LINK_W-1:0] tgt_link_q;

	// Capacity saturates at the table size
	assign cap_c  = (32'(max_items) > NODES) ? CNT_W'(NODES) : CNT_W'(max_items);
	assign full_c = count_q >= cap_c;

	// Location decode: codes above tail are relative; no reference means head
	assign rel_c        = (loc_q != LOC_HEAD) && (loc_q != LOC_TAIL);
	assign head_sel_c   = (loc_q == LOC_HEAD) || (rel_c && !refv_q);
	assign list_empty_c = !is_real(head_q);
	assign id_link      = LINK_W'(id_q);
	assign tgt_link_q   = LINK_W'(tgt_q);

	// Target node: head, tail or reference, for put and get alike
	always_comb begin
		if (head_sel_c) begin
			tgt_link_c = head_q;
		end else if (loc_q == LOC_TAIL) begin
			tgt_link_c = tail_q;
		end else begin
			tgt_link_c = LINK_W'(ref_q);
		end
	end

	// Membership and capacity checks
	always_comb begin
		op_c     = OP_NONE;
		status_c = ST_OK;
		if (act_q == ACT_PUT) begin
			if (full_c) begin
				status_c = ST_FULL;
			end else if (member_q[id_q]) begin
				status_c = ST_BAD;
			end else if (list_empty_c) begin
				op_c = OP_PUT_FIRST;
			end else if (head_sel_c) begin
				op_c = OP_PUT_HEAD;
			end else if (loc_q == LOC_TAIL) begin
				op_c = OP_PUT_TAIL;
			end else if (!member_q[ref_q]) begin
				status_c = ST_BAD;
			end else begin
				op_c = OP_PUT_AFTER;
			end
		end else begin
			if (list_empty_c || (count_q == '0)) begin
				status_c = ST_EMPTY;
			end else if (rel_c && refv_q && !member_q[ref_q]) begin
				status_c = ST_BAD;
			end else if (!is_real(tgt_link_c)) begin
				status_c = ST_EMPTY;
			end else begin
				op_c = OP_GET;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (op_c == OP_NONE) begin
					state_d = S_DONE;
				end else if ((op_c == OP_PUT_AFTER) || (op_c == OP_GET)) begin
					state_d = S_READ;
				end else begin
					state_d = S_WR1;
				end
			end
			S_READ: state_d = S_WR1;
			S_WR1: begin
				if ((op_q == OP_PUT_HEAD) || (op_q == OP_PUT_TAIL) ||
				    (op_q == OP_PUT_AFTER)) begin
					state_d = S_WR2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_WR2:  state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs and RAM requests
	always_comb begin
		busy           = (state_q != S_IDLE);
		done           = (state_q == S_DONE);
		next_req       = '0;
		prev_req       = '0;
		next_req.raddr = tgt_link_c[ID_W-1:0];
		prev_req.raddr = tgt_link_c[ID_W-1:0];
		case (state_q)
			S_WR1: begin
				case (op_q)
					OP_PUT_FIRST: begin
						next_req.we = 1'b1; next_req.waddr = id_q; next_req.wdata = NULL_LINK;
						prev_req.we = 1'b1; prev_req.waddr = id_q; prev_req.wdata = NULL_LINK;
					end
					OP_PUT_HEAD: begin
						next_req.we = 1'b1; next_req.waddr = id_q; next_req.wdata = tgt_link_q;
						prev_req.we = 1'b1; prev_req.waddr = id_q; prev_req.wdata = NULL_LINK;
					end
					OP_PUT_TAIL: begin
						next_req.we = 1'b1; next_req.waddr = id_q; next_req.wdata = NULL_LINK;
						prev_req.we = 1'b1; prev_req.waddr = id_q; prev_req.wdata = tgt_link_q;
					end
					OP_PUT_AFTER: begin
						next_req.we = 1'b1; next_req.waddr = id_q; next_req.wdata = n_q;
						prev_req.we = 1'b1; prev_req.waddr = id_q; prev_req.wdata = tgt_link_q;
					end
					OP_GET: begin
						// Bridge the neighbors around the removed node
						next_req.we    = is_real(p_q);
						next_req.waddr = p_q[ID_W-1:0];
						next_req.wdata = n_q;
						prev_req.we    = is_real(n_q);
						prev_req.waddr = n_q[ID_W-1:0];
						prev_req.wdata = p_q;
					end
					default: begin
						next_req.we = 1'b0;
						prev_req.we = 1'b0;
					end
				endcase
			end
			S_WR2: begin
				case (op_q)
					OP_PUT_HEAD: begin
						prev_req.we = 1'b1; prev_req.waddr = tgt_q; prev_req.wdata = id_link;
					end
					OP_PUT_TAIL: begin
						next_req.we = 1'b1; next_req.waddr = tgt_q; next_req.wdata = id_link;
					end
					OP_PUT_AFTER: begin
						// Successor's back link follows the new node
						next_req.we    = 1'b1;
						next_req.waddr = tgt_q;
						next_req.wdata = id_link;
						prev_req.we    = is_real(n_q);
						prev_req.waddr = n_q[ID_W-1:0];
						prev_req.wdata = id_link;
					end
					default: begin
						next_req.we = 1'b0;
						prev_req.we = 1'b0;
					end
				endcase
			end
			default: begin
				next_req.we = 1'b0;
				prev_req.we = 1'b0;
			end
		endcase
	end

	// Result fields; list state is already updated in the done state
	always_comb begin
		result.removed_node = (op_q == OP_GET) ? tgt_q : '0;
		result.status       = status_q;
		result.item_count   = count_q;
		result.is_empty     = (count_q == '0);
		result.is_full      = full_c;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_NONE;
			status_q <= ST_OK;
			head_q   <= NULL_LINK;
			tail_q   <= NULL_LINK;
			count_q  <= '0;
			member_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK) begin
				op_q     <= op_c;
				status_q <= status_c;
			end
			if (state_q == S_WR1) begin
				case (op_q)
					OP_PUT_FIRST: begin
						head_q <= id_link;
						tail_q <= id_link;
					end
					OP_PUT_HEAD: head_q <= id_link;
					OP_PUT_TAIL: tail_q <= id_link;
					OP_PUT_AFTER: begin
						if (!is_real(n_q)) tail_q <= id_link;
					end
					OP_GET: begin
						if (!is_real(p_q)) head_q <= n_q;
						if (!is_real(n_q)) tail_q <= p_q;
					end
					default: begin
						head_q <= head_q;
					end
				endcase
				if (op_q == OP_GET) begin
					member_q[tgt_q] <= 1'b0;
					count_q         <= count_q - CNT_W'(1);
				end else if (op_q != OP_NONE) begin
					member_q[id_q] <= 1'b1;
					count_q        <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// Transaction and work registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			act_q  <= action;
			loc_q  <= location;
			id_q   <= node_id;
			refv_q <= ref_valid;
			ref_q  <= ref_node;
		end
		if (state_q == S_CHECK) begin
			tgt_q <= tgt_link_c[ID_W-1:0];
		end
		if (state_q == S_READ) begin
			p_q <= prev_rdata_q;
			n_q <= next_rdata_q;
		end
	end

endmodule

>>> rtl/doubly_linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_top
// Doubly linked list manager over 64 node ids with an APB capacity register.
// ----------------------------------------------------------------------------
// An operation is taken when start is high while busy is low; busy then stays
// high until the operation is finished. The sequencer steps through the
// check, a registered read of the link RAMs for a put after a reference or a
// get, and one link write state (put into an empty list, get) or two (put at
// head, tail or after a reference); a refused op goes from check to done.
// The result is registered and appears in the cycle after the done state,
// on the result ports for exactly one cycle with done high; the receiver
// cannot stall it and must take it in that cycle. A new operation may be
// started while that result is still on the ports. The user must write
// max_items (offset 0x0) only while the block is idle; nothing enforces it.
module doubly_linked_list_engine_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// Operation transaction
	input  logic                       start,
	output logic                       busy,
	input  logic                       action,
	input  logic [1:0]                 location,
	input  logic [dlle_pkg::ID_W-1:0]  node_id,
	input  logic                       ref_valid,
	input  logic [dlle_pkg::ID_W-1:0]  ref_node,
	// Result transaction
	output logic                       done,
	output logic [dlle_pkg::ID_W-1:0]  removed_node,
	output logic [1:0]                 status,
	output logic [dlle_pkg::CNT_W-1:0] item_count,
	output logic                       is_empty,
	output logic                       is_full,
	// APB configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import dlle_pkg::*;

	logic [CFG_W-1:0]  max_items_q;
	ram_req_t          next_req;
	ram_req_t          prev_req;
	logic [LINK_W-1:0] next_rdata_q;
	logic [LINK_W-1:0] prev_rdata_q;
	logic              seq_done;
	result_t           seq_result;
	logic              done_q;
	result_t           result_q;
	logic              cfg_wr;

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_MAX_ITEMS) ? 32'(max_items_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_items_q <= MAX_ITEMS_RST;
		end else if (cfg_wr && (paddr[2] == REG_MAX_ITEMS)) begin
			max_items_q <= pwdata[CFG_W-1:0];
		end
	end

	// Forward and backward link tables
	dlle_link_ram u_next_ram (
		.clk     (clk),
		.req     (next_req),
		.rdata_q (next_rdata_q)
	);

	dlle_link_ram u_prev_ram (
		.clk     (clk),
		.req     (prev_req),
		.rdata_q (prev_rdata_q)
	);

	// Operation sequencer
	dlle_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.location     (location),
		.node_id      (node_id),
		.ref_valid    (ref_valid),
		.ref_node     (ref_node),
		.max_items    (max_items_q),
		.next_rdata_q (next_rdata_q),
		.prev_rdata_q (prev_rdata_q),
		.next_req     (next_req),
		.prev_req     (prev_req),
		.busy         (busy),
		.done         (seq_done),
		.result       (seq_result)
	);

	// Result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= seq_done;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			result_q <= seq_result;
		end
	end

	assign done         = done_q;
	assign removed_node = result_q.removed_node;
	assign status       = result_q.status;
	assign item_count   = result_q.item_count;
	assign is_empty     = result_q.is_empty;
	assign is_full      = result_q.is_full;

	// Checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted operation");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (item_count == '0)))
		else $error("is_empty disagrees with item_count");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY) |-> is_empty && (removed_node == '0))
		else $error("empty status reported on a non-empty list");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done))
		else $error("result strobe held for more than one cycle");

endmodule
